// File: rtl/bitmap_contiguous_piece_allocator_macros.svh
// Assertion helpers for the piece allocator.
`ifndef BITMAP_CONTIGUOUS_PIECE_ALLOCATOR_MACROS_SVH
`define BITMAP_CONTIGUOUS_PIECE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BCPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define BCPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: rtl/bcpa_pkg.sv
package bcpa_pkg;

    localparam int NUM_PIECES_DEF = 4096;
    localparam int PIECE_BYTES    = 16;
    localparam int MAP_WORD_BITS  = 32;
    localparam logic [26:0] MAX_REQUEST = 27'd67108864;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_SIZE  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_NOROOM = 2'd2;
    localparam logic [1:0] ST_BADPTR = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [26:0] req_bytes;
        logic [16:0] user_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] alloc_offset;
        logic [15:0] usable_bytes;
        logic [12:0] free_pieces_left;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_LOOKCHK,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_INIT,
        S_MARK_RD,
        S_MARK_WR,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       idle;
        logic       load_in;
        logic       clr_step;
        logic       scan_init;
        logic       scan_step;
        logic       word_next;
        logic       map_rd;
        logic       map_wr;
        logic       rlt_rd;
        logic       lk_take;
        logic       mark_init;
        logic       fin;
        logic       res_load;
        logic [1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] func;
        logic       zero;
        logic       toobig;
        logic       nofit;
        logic       badoff;
        logic       rlt_zero;
        logic       hit;
        logic       chunk_last;
        logic       word_last;
        logic       mark_last;
        logic       out_free;
    } t_sts;

endpackage

// File: rtl/bcpa_ctrl.sv
`include "bitmap_contiguous_piece_allocator_macros.svh"

module bcpa_ctrl
    import bcpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_res_st, n_res_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_res_st <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_res_st <= n_res_st;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_res_st = r_res_st;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_DONE;
                n_res_st = ST_OK;
                case (i_sts.func)
                    FUNC_ALLOC: begin
                        if (i_sts.zero) begin
                            n_res_st = ST_ZERO;
                        end else if (i_sts.toobig || i_sts.nofit) begin
                            n_res_st = ST_NOROOM;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN_RD;
                        end
                    end
                    FUNC_FREE, FUNC_SIZE: begin
                        if (i_sts.badoff) begin
                            n_res_st = ST_BADPTR;
                        end else begin
                            o_cmd.rlt_rd = 1'b1;
                            n_state      = S_LOOK;
                        end
                    end
                    default: n_res_st = ST_OK;
                endcase
            end
            S_LOOK: n_state = S_LOOKCHK;
            S_LOOKCHK: begin
                o_cmd.lk_take = 1'b1;
                n_res_st      = ST_OK;
                if (i_sts.rlt_zero) begin
                    n_res_st = ST_BADPTR;
                    n_state  = S_DONE;
                end else if (i_sts.func == FUNC_SIZE) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MARK_INIT;
                end
            end
            S_SCAN_RD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_MARK_INIT;
                end else if (i_sts.chunk_last) begin
                    if (i_sts.word_last) begin
                        n_res_st = ST_NOROOM;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.word_next = 1'b1;
                        n_state         = S_SCAN_RD;
                    end
                end
            end
            S_MARK_INIT: begin
                o_cmd.mark_init = 1'b1;
                n_state         = S_MARK_RD;
            end
            S_MARK_RD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.map_wr = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.word_next = 1'b1;
                    n_state         = S_MARK_RD;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_res_st  = ST_OK;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_cmd.res_status = r_res_st;
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `BCPA_ASSERT_NEXT(a_hit_marks, i_clk, i_rst_n, (r_state == S_SCAN) && i_sts.hit, r_state == S_MARK_INIT)
    `BCPA_ASSERT_NOW(a_load_idle, i_clk, i_rst_n, o_cmd.load_in, r_state == S_IDLE)
    `BCPA_ASSERT_NEXT(a_wr_follows_rd, i_clk, i_rst_n, (r_state == S_MARK_RD), o_cmd.map_wr)

endmodule

// File: rtl/bcpa_dp.sv
`include "bitmap_contiguous_piece_allocator_macros.svh"

module bcpa_dp
    import bcpa_pkg::*;
#(
    parameter int NUM_PIECES = NUM_PIECES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int MAP_WORDS = (NUM_PIECES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PIW       = WW + 5;
    localparam int PW        = $clog2(NUM_PIECES);
    localparam int FCW       = $clog2(NUM_PIECES + 1);

    logic [31:0]    r_map [MAP_WORDS];
    logic [FCW-1:0] r_rlt [NUM_PIECES];

    t_in_item       r_in;
    logic [PW-1:0]  r_clr;
    logic [WW-1:0]  r_word;
    logic [1:0]     r_chunk;
    logic [FCW-1:0] r_run;
    logic [PIW-1:0] r_rs;
    logic [PIW-1:0] r_start;
    logic [FCW-1:0] r_len;
    logic [FCW-1:0] r_fc;
    logic [31:0]    r_map_q;
    logic [FCW-1:0] r_rlt_q;
    logic           r_out_valid;
    t_out_item      r_out;

    logic [27:0]    len_full;
    logic [16:0]    q;
    logic [PIW:0]   end_p;
    logic [31:0]    mask;
    logic [FCW-1:0] run;
    logic [PIW-1:0] s;
    logic [PIW-1:0] hs;
    logic           hit;
    logic [PIW-1:0] p;
    logic           used;
    logic           res_ok;

    assign len_full = (28'(r_in.req_bytes) + 28'd31) >> 4;
    assign q        = {4'd0, r_in.user_offset[16:4]} - 17'd1;
    assign end_p    = {1'b0, r_start} + (PIW+1)'(r_len) - (PIW+1)'(1);

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            mask[i] = ({r_word, 5'(i)} >= r_start) &&
                      ({1'b0, r_word, 5'(i)} <= end_p);
        end
    end

    always_comb begin
        run  = r_run;
        s    = r_rs;
        hit  = 1'b0;
        hs   = r_rs;
        p    = '0;
        used = 1'b0;
        for (int i = 0; i < 8; i++) begin
            p    = {r_word, r_chunk, 3'(i)};
            used = r_map_q[{r_chunk, 3'(i)}] ||
                   ({1'b0, p} >= (PIW+1)'(NUM_PIECES));
            if (used) begin
                run = '0;
            end else begin
                if (run == '0) s = p;
                run = run + FCW'(1);
                if (!hit && run == r_len) begin
                    hit = 1'b1;
                    hs  = s;
                end
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clr_done   = (r_clr == PW'(NUM_PIECES - 1));
        o_sts.func       = r_in.func;
        o_sts.zero       = (r_in.req_bytes == '0);
        o_sts.toobig     = (r_in.req_bytes > MAX_REQUEST);
        o_sts.nofit      = (len_full > 28'(r_fc));
        o_sts.badoff     = (r_in.user_offset[3:0] != 4'd0) ||
                           (r_in.user_offset[16:4] == 13'd0) ||
                           (q >= 17'(NUM_PIECES));
        o_sts.rlt_zero   = (r_rlt_q == '0);
        o_sts.hit        = hit;
        o_sts.chunk_last = (r_chunk == 2'd3);
        o_sts.word_last  = (r_word == WW'(MAP_WORDS - 1));
        o_sts.mark_last  = (r_word == end_p[PIW-1:5]);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (32'(r_clr) < 32'(MAP_WORDS)) r_map[r_clr[WW-1:0]] <= '0;
            r_rlt[r_clr] <= '0;
        end else begin
            if (i_cmd.map_wr) begin
                if (r_in.func == FUNC_ALLOC) r_map[r_word] <= r_map_q | mask;
                else                         r_map[r_word] <= r_map_q & ~mask;
            end
            if (i_cmd.fin) begin
                if (r_in.func == FUNC_ALLOC) r_rlt[r_start[PW-1:0]] <= r_len;
                else                         r_rlt[r_start[PW-1:0]] <= '0;
            end
        end
        if (i_cmd.map_rd) r_map_q <= r_map[r_word];
        if (i_cmd.rlt_rd) r_rlt_q <= r_rlt[q[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_fc        <= FCW'(NUM_PIECES);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step && !o_sts.clr_done) r_clr <= r_clr + PW'(1);
            if (i_cmd.fin) begin
                if (r_in.func == FUNC_ALLOC) r_fc <= r_fc - r_len;
                else                         r_fc <= r_fc + r_len;
            end
            if (i_cmd.res_load)  r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign res_ok = (i_cmd.res_status == ST_OK);

    // chunk counter wraps to zero on its own when the scan moves to the next word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in_item;
        if (i_cmd.scan_init) begin
            r_word  <= '0;
            r_chunk <= '0;
            r_run   <= '0;
            r_rs    <= '0;
            r_len   <= len_full[FCW-1:0];
        end
        if (i_cmd.scan_step) begin
            r_run   <= run;
            r_rs    <= s;
            r_chunk <= r_chunk + 2'd1;
            if (hit) r_start <= hs;
        end
        if (i_cmd.word_next) begin
            r_word  <= r_word + WW'(1);
        end
        if (i_cmd.lk_take) begin
            r_start <= PIW'(q[PW-1:0]);
            r_len   <= r_rlt_q;
        end
        if (i_cmd.mark_init) r_word <= r_start[PIW-1:5];
        if (i_cmd.res_load) begin
            r_out.status           <= i_cmd.res_status;
            r_out.alloc_offset     <= (res_ok && r_in.func == FUNC_ALLOC) ?
                17'({(PIW+1)'(r_start) + (PIW+1)'(1), 4'd0}) : 17'd0;
            r_out.usable_bytes     <= (res_ok && r_in.func == FUNC_SIZE) ?
                16'({r_len - FCW'(1), 4'd0}) : 16'd0;
            r_out.free_pieces_left <= 13'(r_fc);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `BCPA_ASSERT_NOW(a_fc_bound, i_clk, i_rst_n, 1'b1, r_fc <= FCW'(NUM_PIECES))
    `BCPA_ASSERT_NOW(a_mark_in_run, i_clk, i_rst_n, i_cmd.map_wr, mask != 32'd0)
    `BCPA_ASSERT_NEXT(a_res_shown, i_clk, i_rst_n, i_cmd.res_load, o_out_valid)

endmodule

// File: rtl/bitmap_contiguous_piece_allocator.sv
// A size reads the length table; a free reads it and then clears each bitmap word touched;
// an allocate scans words (8 pieces a cycle while scanning, with a map read before each
// word, one map read port) and then marks each word; an item rejected at decode goes
// straight to the result. One item at a time, the next taken in the cycle after the result is loaded.
// Reset is synchronous; afterwards a sweep clears the length table and bitmap,
// during which no item is taken.
module bitmap_contiguous_piece_allocator
    import bcpa_pkg::*;
#(
    parameter int NUM_PIECES = NUM_PIECES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd cmd;
    t_sts sts;

    bcpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bcpa_dp #(
        .NUM_PIECES (NUM_PIECES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = !cmd.idle;

endmodule

// File: tb/tb_bitmap_contiguous_piece_allocator.sv
module tb_bitmap_contiguous_piece_allocator;
    import bcpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPC = 4096;
    localparam int WATCHDOG_CYCLES = 40000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    bitmap_contiguous_piece_allocator dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    bit        piece_busy[NPC];
    int        run_len[NPC];
    int        free_cnt;
    int        live_offs[$];

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    bit        stim_done = 0;
    bit        in_took = 0;
    int        in_gap = 0;
    int        out_gap = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_out_item predict_alloc(t_in_item it);
        t_out_item res;
        int need, run, s, p, q;
        bit found;
        res = '0;
        found = 0;
        s = 0;
        case (it.func)
            FUNC_ALLOC: begin
                if (it.req_bytes == 0) begin
                    res.status = ST_ZERO;
                end else if (it.req_bytes > MAX_REQUEST) begin
                    res.status = ST_NOROOM;
                end else begin
                    need = (int'(it.req_bytes) + 2 * PIECE_BYTES - 1) / PIECE_BYTES;
                    run = 0;
                    if (need <= free_cnt) begin
                        for (p = 0; p < NPC && !found; p++) begin
                            if (piece_busy[p]) begin
                                run = 0;
                            end else begin
                                if (run == 0) s = p;
                                run++;
                                if (run == need) found = 1;
                            end
                        end
                    end
                    if (!found) begin
                        res.status = ST_NOROOM;
                    end else begin
                        for (p = s; p < s + need; p++) piece_busy[p] = 1;
                        run_len[s] = need;
                        free_cnt -= need;
                        res.alloc_offset = 17'((s + 1) * PIECE_BYTES);
                        live_offs.push_back((s + 1) * PIECE_BYTES);
                    end
                end
            end
            FUNC_FREE, FUNC_SIZE: begin
                q = int'(it.user_offset) / PIECE_BYTES - 1;
                if (it.user_offset % PIECE_BYTES != 0 || it.user_offset < PIECE_BYTES
                        || q >= NPC || run_len[q] == 0) begin
                    res.status = ST_BADPTR;
                end else if (it.func == FUNC_SIZE) begin
                    res.usable_bytes = 16'((run_len[q] - 1) * PIECE_BYTES);
                end else begin
                    for (p = q; p < q + run_len[q]; p++) piece_busy[p] = 0;
                    free_cnt += run_len[q];
                    run_len[q] = 0;
                    foreach (live_offs[i])
                        if (live_offs[i] == int'(it.user_offset)) begin
                            live_offs.delete(i);
                            break;
                        end
                end
            end
            default: ;
        endcase
        res.free_pieces_left = 13'(free_cnt);
        return res;
    endfunction

    function automatic t_in_item mk(logic [1:0] f, int req, int off);
        t_in_item it;
        it.func = f;
        it.req_bytes = 27'(req);
        it.user_offset = 17'(off);
        return it;
    endfunction

    // small requests mostly, with a few large ones
    function automatic int rand_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 400);
        if (r < 90) return $urandom_range(1, 4000);
        if (r < 97) return $urandom_range(1, 65536);
        return $urandom_range(0, 27'h7FFFFFF);
    endfunction

    initial begin
        int k, r, pick;
        // directed: extremes and every special case
        pending_items.push_back(mk(FUNC_ALLOC, 0, 0));
        pending_items.push_back(mk(FUNC_ALLOC, 67108865, 0));
        pending_items.push_back(mk(FUNC_ALLOC, 27'h7FFFFFF, 0));
        pending_items.push_back(mk(FUNC_ALLOC, 67108864, 0));
        pending_items.push_back(mk(FUNC_ALLOC, 1, 0));
        pending_items.push_back(mk(FUNC_ALLOC, 16, 0));
        pending_items.push_back(mk(FUNC_ALLOC, 17, 0));
        pending_items.push_back(mk(FUNC_SIZE, 0, 16));
        pending_items.push_back(mk(FUNC_SIZE, 0, 48));
        pending_items.push_back(mk(FUNC_SIZE, 0, 0));
        pending_items.push_back(mk(FUNC_SIZE, 0, 17));
        pending_items.push_back(mk(FUNC_SIZE, 0, 17'h1FFFF));
        pending_items.push_back(mk(FUNC_FREE, 0, 65536));
        pending_items.push_back(mk(FUNC_FREE, 0, 32));
        pending_items.push_back(mk(FUNC_FREE, 0, 48));
        pending_items.push_back(mk(FUNC_FREE, 0, 48));
        pending_items.push_back(mk(2'd3, 27'h7FFFFFF, 17'h1FFFF));
        pending_items.push_back(mk(FUNC_ALLOC, 65520 - 16, 0));
        pending_items.push_back(mk(FUNC_ALLOC, 65536, 0));
        pending_items.push_back(mk(FUNC_FREE, 0, 16));
        pending_items.push_back(mk(FUNC_ALLOC, 65504, 0));
        pending_items.push_back(mk(FUNC_SIZE, 0, 16));
        pending_items.push_back(mk(FUNC_FREE, 0, 16));
        // random: free and size items get offsets of random pieces; live block offsets are
        // tracked by the predictor at acceptance, and the driver substitutes one of them for
        // the random offset at send time, since a generator-side shadow applied at generation
        // time would diverge.
        for (k = 0; k < 1850; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                pending_items.push_back(mk(FUNC_ALLOC, rand_req(), $urandom));
            end else if (r < 75) begin
                pick = ($urandom_range(0, 255) + 1) * PIECE_BYTES;
                pending_items.push_back(mk(FUNC_FREE, $urandom, pick));
            end else if (r < 93) begin
                pick = ($urandom_range(0, 255) + 1) * PIECE_BYTES;
                pending_items.push_back(mk(FUNC_SIZE, $urandom, pick));
            end else if (r < 97) begin
                pending_items.push_back(mk(2'($urandom_range(1, 2)), $urandom,
                                           $urandom_range(0, 17'h1FFFF)));
            end else begin
                pending_items.push_back(mk(2'd3, $urandom, $urandom));
            end
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        free_cnt = NPC;
        foreach (run_len[i]) run_len[i] = 0;
    end

    // driver; live offsets replace aligned random free/size offsets three times in four
    always @(negedge i_clk) begin
        t_in_item it;
        if (i_rst_n) begin
            if (i_in_valid && in_took) begin
                i_in_valid <= 1'b0;
                in_gap = pick_gap();
            end else if (!i_in_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    if ((it.func == FUNC_FREE || it.func == FUNC_SIZE)
                            && it.user_offset[3:0] == 0 && live_offs.size() > 0
                            && $urandom_range(0, 3) != 0)
                        it.user_offset = 17'(live_offs[$urandom_range(0, live_offs.size() - 1)]);
                    i_in_item <= it;
                    i_in_valid <= 1'b1;
                end else begin
                    stim_done = 1;
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 9) == 0) out_gap = pick_gap();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_res;
        bit moved;
        moved = 0;
        in_took = 0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_alloc(i_in_item));
                moved = 1;
                in_took = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result item");
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_out_item.status !== exp_res.status) begin
                        $error("status exp %0d got %0d", exp_res.status, o_out_item.status);
                        errors++;
                    end
                    if (o_out_item.alloc_offset !== exp_res.alloc_offset) begin
                        $error("alloc_offset exp %0d got %0d", exp_res.alloc_offset,
                               o_out_item.alloc_offset);
                        errors++;
                    end
                    if (o_out_item.usable_bytes !== exp_res.usable_bytes) begin
                        $error("usable_bytes exp %0d got %0d", exp_res.usable_bytes,
                               o_out_item.usable_bytes);
                        errors++;
                    end
                    if (o_out_item.free_pieces_left !== exp_res.free_pieces_left) begin
                        $error("free_pieces_left exp %0d got %0d",
                               exp_res.free_pieces_left, o_out_item.free_pieces_left);
                        errors++;
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("FAIL bitmap_contiguous_piece_allocator");
            $finish;
        end
    end

    initial begin
        wait (stim_done && !i_in_valid && expected_results.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS bitmap_contiguous_piece_allocator");
        end else begin
            $display("FAIL bitmap_contiguous_piece_allocator");
        end
        $finish;
    end
endmodule
